// ===== rtl/ipv4_trie_pkg.sv =====
`timescale 1ns / 1ps
package ipv4_trie_pkg;

  localparam int IDX_W          = 10;
  localparam int SLOT_W         = 8;
  localparam int ADDR_W         = 32;
  localparam int HOP_BITS       = 32;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int NODE_COUNT_DEF = 1024;
  localparam int HOP_WIDTH_DEF  = 32;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_NODE      = 2'd0,
    CFG_DEFAULT_ENABLE = 2'd1,
    CFG_DEFAULT_HOP    = 2'd2,
    CFG_IPV4_TABLE     = 2'd3
  } cfg_idx_t;

  // one node entry as seen outside the store
  typedef struct packed {
    logic                valid;
    logic [HOP_BITS-1:0] hop;
    logic [IDX_W-1:0]    child;
  } entry_t;

  // lookup context handed from cell to cell
  typedef struct packed {
    logic                live;
    logic                pending;
    logic                go;
    logic                hit;
    logic [HOP_BITS-1:0] hop;
    logic [IDX_W-1:0]    node;
    logic [ADDR_W-1:0]   addr;
  } ctx_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  node;
    logic [SLOT_W-1:0] slot;
  } rd_req_t;

  typedef struct packed {
    logic                found;
    logic [HOP_BITS-1:0] hop;
  } result_t;

  // fold the entry read for the previous level into the context
  function automatic ctx_t merge_entry(ctx_t c, entry_t e);
    ctx_t m;
    m = c;
    if (c.pending) begin
      if (e.valid) begin
        m.hit = 1'b1;
        m.hop = e.hop;
      end
      m.node = e.child;
      m.go   = (e.child != '0);
    end
    return m;
  endfunction

endpackage

// ===== rtl/ipv4_trie_if.sv =====
`timescale 1ns / 1ps
interface ipv4_trie_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic [ipv4_trie_pkg::ADDR_W-1:0]     ip_address;
  logic [ipv4_trie_pkg::IDX_W-1:0]      node_sel;
  logic [ipv4_trie_pkg::SLOT_W-1:0]     slot;
  logic [ipv4_trie_pkg::IDX_W-1:0]      new_child;
  logic                                 new_valid;
  logic [ipv4_trie_pkg::HOP_BITS-1:0]   new_hop;

  modport source (output valid, op, ip_address, node_sel, slot, new_child, new_valid,
                  new_hop, input ready);
  modport sink (input valid, op, ip_address, node_sel, slot, new_child, new_valid,
                new_hop, output ready);
endinterface

interface ipv4_trie_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic [ipv4_trie_pkg::HOP_BITS-1:0] route_hop;

  modport source (output valid, found, route_hop, input ready);
  modport sink (input valid, found, route_hop, output ready);
endinterface

// ===== rtl/ipv4_trie_store.sv =====
`timescale 1ns / 1ps
module ipv4_trie_store #(
  parameter int NODE_COUNT = ipv4_trie_pkg::NODE_COUNT_DEF,
  parameter int HOP_WIDTH  = ipv4_trie_pkg::HOP_WIDTH_DEF,
  localparam int MEM_DEPTH = NODE_COUNT * 256,
  localparam int MEM_AW    = $clog2(MEM_DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic                  re,
  input  logic [MEM_AW-1:0]     addr,
  input  ipv4_trie_pkg::entry_t wdata,
  output ipv4_trie_pkg::entry_t rdata
);

  localparam int ENTRY_W = 1 + HOP_WIDTH + ipv4_trie_pkg::IDX_W;

  logic [ENTRY_W-1:0] mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] word;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= {wdata.valid, wdata.hop[HOP_WIDTH-1:0], wdata.child};
    end else if (re) begin
      word <= mem[addr];
    end
  end

  always_comb begin
    rdata.valid = word[ENTRY_W-1];
    rdata.hop   = ipv4_trie_pkg::HOP_BITS'(word[ENTRY_W-2 -: HOP_WIDTH]);
    rdata.child = word[ipv4_trie_pkg::IDX_W-1:0];
  end

endmodule

// ===== rtl/ipv4_trie_cell.sv =====
`timescale 1ns / 1ps
module ipv4_trie_cell #(
  parameter int NODE_COUNT = ipv4_trie_pkg::NODE_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ipv4_trie_pkg::ctx_t    ctx_in,
  input  ipv4_trie_pkg::entry_t  rd_data,
  output ipv4_trie_pkg::ctx_t    ctx_out,
  output ipv4_trie_pkg::rd_req_t rd,
  output logic                   busy
);

  ipv4_trie_pkg::ctx_t ctx;
  ipv4_trie_pkg::ctx_t m;
  logic                in_range;
  logic                issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '0;
    end else begin
      ctx <= ctx_in;
    end
  end

  always_comb begin
    m        = ipv4_trie_pkg::merge_entry(ctx, rd_data);
    in_range = (32'(m.node) < 32'(NODE_COUNT));
    issue    = m.live && m.go && in_range;

    // top address byte indexes this level, then shifts out
    ctx_out         = m;
    ctx_out.pending = issue;
    ctx_out.go      = issue;
    ctx_out.addr    = {m.addr[ipv4_trie_pkg::ADDR_W-ipv4_trie_pkg::SLOT_W-1:0],
                       ipv4_trie_pkg::SLOT_W'(0)};

    rd.en   = issue;
    rd.node = issue ? m.node : '0;
    rd.slot = issue ? m.addr[ipv4_trie_pkg::ADDR_W-1 -: ipv4_trie_pkg::SLOT_W] : '0;
  end

  assign busy = ctx.live;

endmodule

// ===== rtl/ipv4_trie_result.sv =====
`timescale 1ns / 1ps
module ipv4_trie_result (
  input  logic                  clk,
  input  logic                  rst,
  input  ipv4_trie_pkg::ctx_t   ctx_in,
  input  ipv4_trie_pkg::entry_t rd_data,
  input  logic                  prev_busy,
  input  logic                  default_enable,
  input  logic [ipv4_trie_pkg::HOP_BITS-1:0] default_hop,
  input  logic                  ipv4_table,
  output logic                  room,
  ipv4_trie_rsp_if.source       rsp
);

  ipv4_trie_pkg::ctx_t    ctx;
  ipv4_trie_pkg::ctx_t    m;
  ipv4_trie_pkg::result_t res;
  ipv4_trie_pkg::result_t q [2];
  logic [1:0]             cnt;
  logic [1:0]             cnt_next;
  logic                   push;
  logic                   pop;
  logic                   wr_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '0;
    end else begin
      ctx <= ctx_in;
    end
  end

  // last level: its child is not followed
  always_comb begin
    m = ipv4_trie_pkg::merge_entry(ctx, rd_data);
    priority if (!ipv4_table) begin
      res = '0;
    end else if (m.hit) begin
      res.found = 1'b1;
      res.hop   = m.hop;
    end else if (default_enable) begin
      res.found = 1'b1;
      res.hop   = default_hop;
    end else begin
      res = '0;
    end
  end

  assign push     = ctx.live;
  assign pop      = rsp.valid && rsp.ready;
  assign wr_pos   = 1'(cnt - 2'(pop));
  assign cnt_next = cnt + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // head slot takes the new result when it lands there, else shifts on a pop
  always_ff @(posedge clk) begin
    if (push && !wr_pos) begin
      q[0] <= res;
    end else if (pop) begin
      q[0] <= q[1];
    end
    if (push && wr_pos) begin
      q[1] <= res;
    end
  end

  // slots left for results still on their way
  assign room = ({1'b0, cnt} + 3'(prev_busy) + 3'(ctx.live)) < 3'd2;

  assign rsp.valid     = (cnt != 2'd0);
  assign rsp.found     = q[0].found;
  assign rsp.route_hop = q[0].hop;

endmodule

// ===== rtl/ipv4_stride8_trie_lookup.sv =====
`timescale 1ns / 1ps
// lookups: a new one is taken only once the last has left cells 0..2,
// with one read of the single-ported node memory per level
// write items: one per cycle while no lookup holds cells 0..2 and the result queue has room
// reset (rst, synchronous): config to root 0, default off, default hop 0, ipv4 table on,
// then a clearing pass of NODE_COUNT*256 entries (262144 by default) with req.ready low
module ipv4_stride8_trie_lookup #(
  parameter int NODE_COUNT = ipv4_trie_pkg::NODE_COUNT_DEF,
  parameter int HOP_WIDTH  = ipv4_trie_pkg::HOP_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ipv4_trie_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipv4_trie_pkg::CFG_W-1:0]       cfg_data,
  ipv4_trie_req_if.sink                         req,
  ipv4_trie_rsp_if.source                       rsp
);

  localparam int MEM_DEPTH = NODE_COUNT * 256;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int NODE_AW   = MEM_AW - ipv4_trie_pkg::SLOT_W;
  localparam int LEVELS    = 4;

  // configuration registers
  logic [ipv4_trie_pkg::IDX_W-1:0]    root_node;
  logic                               default_enable;
  logic [ipv4_trie_pkg::HOP_BITS-1:0] default_hop;
  logic                               ipv4_table;

  // clearing pass
  logic              clearing;
  logic [MEM_AW-1:0] clr_addr;

  // write item goes through a register so it never meets a level read
  logic                  wr_pend;
  logic [MEM_AW-1:0]     wr_addr;
  ipv4_trie_pkg::entry_t wr_data;

  // cell chain
  ipv4_trie_pkg::ctx_t    link [LEVELS+1];
  ipv4_trie_pkg::rd_req_t rd [LEVELS];
  logic [LEVELS-1:0]      busy;
  ipv4_trie_pkg::rd_req_t rd_any;

  // store port
  logic                  mem_we;
  logic [MEM_AW-1:0]     mem_addr;
  ipv4_trie_pkg::entry_t mem_wdata;
  ipv4_trie_pkg::entry_t rd_data;

  logic room;
  logic accept;
  logic is_lookup;
  logic wr_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node      <= '0;
      default_enable <= 1'b0;
      default_hop    <= '0;
      ipv4_table     <= 1'b1;
    end else if (cfg_we) begin
      unique case (ipv4_trie_pkg::cfg_idx_t'(cfg_index))
        ipv4_trie_pkg::CFG_ROOT_NODE:      root_node      <= cfg_data[ipv4_trie_pkg::IDX_W-1:0];
        ipv4_trie_pkg::CFG_DEFAULT_ENABLE: default_enable <= cfg_data[0];
        ipv4_trie_pkg::CFG_DEFAULT_HOP:    default_hop    <= cfg_data;
        ipv4_trie_pkg::CFG_IPV4_TABLE:     ipv4_table     <= cfg_data[0];
      endcase
    end
  end

  // sweep every entry to invalid, no child
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // cell 3 reads in the accepting cycle and a new lookup reads in the next one,
  // so only a lookup in cells 0..2 keeps the memory port
  assign req.ready = !clearing && !busy[0] && !busy[1] && !busy[2] && room;
  assign accept    = req.valid && req.ready;
  assign is_lookup = (req.op == ipv4_trie_pkg::OP_LOOKUP);
  assign wr_in_range = (32'(req.node_sel) < 32'(NODE_COUNT));

  // writes to a node beyond the store are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= accept && !is_lookup && wr_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_lookup) begin
      wr_addr       <= {NODE_AW'(req.node_sel), req.slot};
      wr_data.valid <= req.new_valid;
      wr_data.hop   <= req.new_hop;
      wr_data.child <= req.new_child;
    end
  end

  // a new lookup enters cell 0 at the root
  always_comb begin
    link[0]         = '0;
    link[0].live    = accept && is_lookup;
    link[0].go      = 1'b1;
    link[0].node    = root_node;
    link[0].addr    = req.ip_address;
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    ipv4_trie_cell #(
      .NODE_COUNT (NODE_COUNT)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctx_in  (link[k]),
      .rd_data (rd_data),
      .ctx_out (link[k+1]),
      .rd      (rd[k]),
      .busy    (busy[k])
    );
  end

  // at most one cell reads in any cycle, idle cells drive zeros
  always_comb begin
    rd_any = '0;
    for (int k = 0; k < LEVELS; k++) begin
      rd_any = rd_any | rd[k];
    end
  end

  always_comb begin
    mem_we    = clearing || wr_pend;
    mem_wdata = clearing ? '0 : wr_data;
    priority if (clearing) begin
      mem_addr = clr_addr;
    end else if (wr_pend) begin
      mem_addr = wr_addr;
    end else begin
      mem_addr = {NODE_AW'(rd_any.node), rd_any.slot};
    end
  end

  ipv4_trie_store #(
    .NODE_COUNT (NODE_COUNT),
    .HOP_WIDTH  (HOP_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (rd_any.en),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rd_data)
  );

  // last cell's read is folded in here, result goes to a two-beat queue
  ipv4_trie_result u_result (
    .clk            (clk),
    .rst            (rst),
    .ctx_in         (link[LEVELS]),
    .rd_data        (rd_data),
    .prev_busy      (busy[LEVELS-1]),
    .default_enable (default_enable),
    .default_hop    (default_hop),
    .ipv4_table     (ipv4_table),
    .room           (room),
    .rsp            (rsp)
  );

endmodule

// ===== rtl/ipv4_trie_chk.sv =====
`timescale 1ns / 1ps
module ipv4_trie_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 req_valid,
  input logic                                 req_ready,
  input logic                                 req_op,
  input logic                                 rsp_valid,
  input logic                                 rsp_ready,
  input logic                                 rsp_found,
  input logic [ipv4_trie_pkg::HOP_BITS-1:0]   rsp_route_hop
);

  logic lookup_beat;
  assign lookup_beat = req_valid && req_ready && (req_op == ipv4_trie_pkg::OP_LOOKUP);

  // after reset nothing is offered and nothing is taken
  a_reset_quiet: assert property (@(posedge clk) rst |=> !req_ready && !rsp_valid)
    else $error("ready or valid high right after reset");

  // one lookup at a time in the first cells
  a_one_lookup: assert property (@(posedge clk) disable iff (rst)
    lookup_beat |=> !req_ready)
    else $error("request accepted while a lookup holds cell 0");

  // a result appearing on an empty output comes from an earlier lookup beat
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(lookup_beat, 6))
    else $error("result beat without a matching lookup");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_route_hop))
    else $error("stalled result beat changed or dropped");

endmodule

bind ipv4_stride8_trie_lookup ipv4_trie_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_op        (req.op),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_found     (rsp.found),
  .rsp_route_hop (rsp.route_hop)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  // the block clears its node store after reset, one entry per cycle
  localparam int CLEAR_CYCLES = ipv4_trie_pkg::NODE_COUNT_DEF * 256;
  // clearing pass plus ~1850 beats at worst-case gaps and stalls, several times over
  localparam int LIMIT_CYCLES = CLEAR_CYCLES + 400000;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_GAP      = 10;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    ipv4_trie_pkg::op_t                 op;
    logic [ipv4_trie_pkg::ADDR_W-1:0]   ip_address;
    logic [ipv4_trie_pkg::IDX_W-1:0]    node_sel;
    logic [ipv4_trie_pkg::SLOT_W-1:0]   slot;
    logic [ipv4_trie_pkg::IDX_W-1:0]    new_child;
    logic                               new_valid;
    logic [ipv4_trie_pkg::HOP_BITS-1:0] new_hop;
  } trie_req_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we;
  logic [ipv4_trie_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ipv4_trie_pkg::CFG_W-1:0]     cfg_data;

  ipv4_trie_req_if req_bus ();
  ipv4_trie_rsp_if rsp_bus ();

  ipv4_stride8_trie_lookup u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the configuration registers
  logic [ipv4_trie_pkg::IDX_W-1:0]    root_q;
  logic                               use_default;
  logic [ipv4_trie_pkg::HOP_BITS-1:0] default_hop_q;
  logic                               ipv4_on;

  // shadow node store, sparse: an entry never written reads as invalid, no child
  ipv4_trie_pkg::entry_t node_mem [bit [ipv4_trie_pkg::IDX_W+ipv4_trie_pkg::SLOT_W-1:0]];

  trie_req_t              req_backlog [$];  // items waiting for the driver
  ipv4_trie_pkg::result_t hops_due [$];     // predicted lookup answers, oldest first

  int  n_errors = 0;
  int  n_beats  = 0;
  int  cycle    = 0;
  bit  hold_rsp = 1'b0;

  // beat counts at which the receiver holds off for a long stretch
  int  hold_at [2] = '{300, 1200};

  // address bytes that routes and lookups keep coming back to, so walks go deep
  logic [7:0] hot_bytes [6] = '{8'h00, 8'hFF, 8'h0A, 8'h55, 8'hAA, 8'h81};

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("mismatch at cycle %0d: %s", cycle, msg);
  endtask

  function automatic ipv4_trie_pkg::entry_t read_entry(
      logic [ipv4_trie_pkg::IDX_W-1:0] node, logic [ipv4_trie_pkg::SLOT_W-1:0] slot);
    bit [ipv4_trie_pkg::IDX_W+ipv4_trie_pkg::SLOT_W-1:0] key;
    key = {node, slot};
    if (node_mem.exists(key)) return node_mem[key];
    return '0;
  endfunction

  // longest-prefix match over up to four stride-8 levels
  function automatic ipv4_trie_pkg::result_t lpm_lookup(
      logic [ipv4_trie_pkg::ADDR_W-1:0] addr);
    ipv4_trie_pkg::result_t             r;
    logic                               hit;
    logic [ipv4_trie_pkg::HOP_BITS-1:0] hop;
    logic [ipv4_trie_pkg::IDX_W-1:0]    node;
    ipv4_trie_pkg::entry_t              e;
    r    = '0;
    hit  = 1'b0;
    hop  = '0;
    node = root_q;
    // table without ipv4 depth misses outright, default route or not
    if (!ipv4_on) return r;
    for (int lvl = 0; lvl < 4; lvl++) begin
      if (int'(node) >= ipv4_trie_pkg::NODE_COUNT_DEF) break;
      e = read_entry(node, addr[31-8*lvl -: 8]);
      // deepest valid entry wins, whatever hop it holds
      if (e.valid) begin
        hit = 1'b1;
        hop = e.hop;
      end
      // child 0 ends the walk; the fourth level's child is never followed
      node = e.child;
      if (node == '0) break;
    end
    if (hit) begin
      r.found = 1'b1;
      r.hop   = hop;
    end else if (use_default) begin
      r.found = 1'b1;
      r.hop   = default_hop_q;
    end
    return r;
  endfunction

  // fold one accepted request beat into the shadow state
  task automatic apply_beat(trie_req_t r);
    ipv4_trie_pkg::entry_t e;
    if (r.op == ipv4_trie_pkg::OP_WRITE) begin
      e.valid = r.new_valid;
      e.hop   = r.new_hop;
      e.child = r.new_child;
      node_mem[{r.node_sel, r.slot}] = e;
    end else begin
      hops_due.push_back(lpm_lookup(r.ip_address));
    end
  endtask

  function automatic trie_req_t wr(logic [ipv4_trie_pkg::IDX_W-1:0] node,
                                   logic [ipv4_trie_pkg::SLOT_W-1:0] slot,
                                   logic [ipv4_trie_pkg::IDX_W-1:0] child, logic valid,
                                   logic [ipv4_trie_pkg::HOP_BITS-1:0] hop);
    trie_req_t r;
    r = '{ipv4_trie_pkg::OP_WRITE, '0, node, slot, child, valid, hop};
    return r;
  endfunction

  function automatic trie_req_t lk(logic [ipv4_trie_pkg::ADDR_W-1:0] addr);
    trie_req_t r;
    r = '{ipv4_trie_pkg::OP_LOOKUP, addr, '0, '0, '0, 1'b0, '0};
    return r;
  endfunction

  // small node pool so links form chains and loops, now and then any node
  function automatic logic [ipv4_trie_pkg::IDX_W-1:0] pick_node();
    if ($urandom_range(0, 9) == 0) return ipv4_trie_pkg::IDX_W'($urandom_range(0, 1023));
    if ($urandom_range(0, 7) == 0) return '1;
    return ipv4_trie_pkg::IDX_W'($urandom_range(0, 6));
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return hot_bytes[$urandom_range(0, 5)];
  endfunction

  function automatic trie_req_t rand_req();
    trie_req_t r;
    r.op = ($urandom_range(0, 9) < 6) ? ipv4_trie_pkg::OP_LOOKUP : ipv4_trie_pkg::OP_WRITE;
    // mostly addresses along known routes, some pure noise
    if ($urandom_range(0, 7) == 0) r.ip_address = $urandom;
    else r.ip_address = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    r.node_sel  = pick_node();
    r.slot      = pick_byte();
    r.new_child = ($urandom_range(0, 3) == 0) ? '0 : pick_node();
    r.new_valid = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       r.new_hop = '0;
      1:       r.new_hop = '1;
      default: r.new_hop = $urandom;
    endcase
    return r;
  endfunction

  // all four registers on back-to-back edges; ends at a falling edge
  task automatic program_regs(logic [ipv4_trie_pkg::IDX_W-1:0] root, logic den,
                              logic [ipv4_trie_pkg::HOP_BITS-1:0] dhop, logic v4);
    cfg_we    <= 1'b1;
    cfg_index <= ipv4_trie_pkg::CFG_ROOT_NODE;
    cfg_data  <= ipv4_trie_pkg::CFG_W'(root);
    @(posedge clk);
    cfg_index <= ipv4_trie_pkg::CFG_DEFAULT_ENABLE;
    cfg_data  <= ipv4_trie_pkg::CFG_W'(den);
    @(posedge clk);
    cfg_index <= ipv4_trie_pkg::CFG_DEFAULT_HOP;
    cfg_data  <= dhop;
    @(posedge clk);
    cfg_index <= ipv4_trie_pkg::CFG_IPV4_TABLE;
    cfg_data  <= ipv4_trie_pkg::CFG_W'(v4);
    @(posedge clk);
    cfg_we <= 1'b0;
    root_q        = root;
    use_default   = den;
    default_hop_q = dhop;
    ipv4_on       = v4;
    @(negedge clk);
  endtask

  // queue random items, then wait until every beat is in and every answer out
  task automatic run_phase(int n_random);
    repeat (n_random) req_backlog.push_back(rand_req());
    while (req_backlog.size() != 0 || req_bus.valid || hops_due.size() != 0)
      @(negedge clk);
    // writes give no answer, so let the pipeline settle before touching registers
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // request driver: random per-item gap up to MAX_GAP, with bursts of no gap at all
  trie_req_t cur;
  int        send_gap   = 0;
  bit        send_burst = 1'b0;

  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      req_bus.valid      <= 1'b0;
      req_bus.op         <= ipv4_trie_pkg::OP_WRITE;
      req_bus.ip_address <= '0;
      req_bus.node_sel   <= '0;
      req_bus.slot       <= '0;
      req_bus.new_child  <= '0;
      req_bus.new_valid  <= 1'b0;
      req_bus.new_hop    <= '0;
    end else begin
      offer = req_bus.valid;
      if (req_bus.valid && req_bus.ready) begin
        apply_beat(cur);
        n_beats++;
        offer = 1'b0;
        if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_backlog.size() != 0) begin
          cur    = req_backlog.pop_front();
          offer  = 1'b1;
          req_bus.op         <= cur.op;
          req_bus.ip_address <= cur.ip_address;
          req_bus.node_sel   <= cur.node_sel;
          req_bus.slot       <= cur.slot;
          req_bus.new_child  <= cur.new_child;
          req_bus.new_valid  <= cur.new_valid;
          req_bus.new_hop    <= cur.new_hop;
        end
      end
      // valid stays high across back-to-back beats, one assignment per edge
      req_bus.valid <= offer;
    end
  end

  // result monitor and receiver: random stall up to MAX_GAP after each beat
  int take_gap   = 0;
  bit take_burst = 1'b0;

  always @(posedge clk) begin
    ipv4_trie_pkg::result_t want;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (hops_due.size() == 0) begin
          report_mismatch($sformatf("result beat with no lookup pending (found %b hop %h)",
                                    rsp_bus.found, rsp_bus.route_hop));
        end else begin
          want = hops_due.pop_front();
          if (rsp_bus.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", rsp_bus.found, want.found));
          if (rsp_bus.route_hop !== want.hop)
            report_mismatch($sformatf("route_hop %h, expected %h",
                                      rsp_bus.route_hop, want.hop));
        end
        if ($urandom_range(0, 29) == 0) take_burst = !take_burst;
        take_gap = take_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else if (take_gap > 0) begin
        take_gap--;
      end
      rsp_bus.ready <= (take_gap == 0) && !hold_rsp;
    end
  end

  // long receiver hold-offs while the driver keeps pushing, so the block backs up
  initial begin
    foreach (hold_at[i]) begin
      wait (n_beats >= hold_at[i]);
      @(posedge clk);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_rsp <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle++;
    if (cycle >= LIMIT_CYCLES) begin
      $display("FAIL ipv4_stride8_trie_lookup");
      $finish;
    end
  end

  initial begin
    cfg_we    = 1'b0;
    cfg_index = ipv4_trie_pkg::CFG_ROOT_NODE;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset values written back, root at node 0
    program_regs('0, 1'b0, '0, 1'b1);
    // empty store misses
    req_backlog.push_back(lk(32'h0000_0000));
    // four-level chain 10.1.2.3, invalid entry at level two
    req_backlog.push_back(wr(10'd0, 8'h0A, 10'd1, 1'b1, 32'h0A00_0001));
    req_backlog.push_back(wr(10'd1, 8'h01, 10'd2, 1'b0, 32'hDEAD_BEEF));
    req_backlog.push_back(wr(10'd2, 8'h02, 10'd3, 1'b1, 32'h0A01_0203));
    // fourth level links back to node 1, which must not be followed
    req_backlog.push_back(wr(10'd3, 8'h03, 10'd1, 1'b1, 32'hFFFF_FFFF));
    req_backlog.push_back(lk(32'h0A01_0203));
    req_backlog.push_back(lk(32'h0A01_0204));  // deepest valid is level three
    req_backlog.push_back(lk(32'h0A01_0909));  // walk stops early, level one hop kept
    req_backlog.push_back(lk(32'h0A09_0909));
    req_backlog.push_back(lk(32'h0B00_0000));  // no match, default off
    // valid entry with hop zero still matches
    req_backlog.push_back(wr(10'd0, 8'hFF, 10'd0, 1'b1, 32'h0000_0000));
    req_backlog.push_back(lk(32'hFFFF_FFFF));
    // self-loop on node 4: walk ends after four levels
    req_backlog.push_back(wr(10'd0, 8'h44, 10'd4, 1'b0, 32'h0000_0000));
    req_backlog.push_back(wr(10'd4, 8'h44, 10'd4, 1'b1, 32'h4444_4444));
    req_backlog.push_back(lk(32'h4444_4444));
    req_backlog.push_back(lk(32'h4444_4400));
    // highest node and child index
    req_backlog.push_back(wr(10'd1023, 8'h00, 10'd0, 1'b1, 32'h8000_0000));
    req_backlog.push_back(wr(10'd0, 8'h00, 10'd1023, 1'b0, 32'h0000_0001));
    req_backlog.push_back(lk(32'h0000_0000));
    // overwrite an entry back to invalid
    req_backlog.push_back(wr(10'd0, 8'hFF, 10'd0, 1'b0, 32'hFFFF_FFFF));
    req_backlog.push_back(lk(32'hFFFF_FFFF));
    run_phase(700);

    // root at the top node, default route on with all-ones hop
    program_regs('1, 1'b1, '1, 1'b1);
    req_backlog.push_back(lk(32'h0000_0000));
    req_backlog.push_back(lk(32'h0102_0304));
    run_phase(400);

    // root inside the pool, default route answering hop zero
    program_regs(10'd3, 1'b1, '0, 1'b1);
    run_phase(400);

    // no ipv4 depth: every lookup misses despite the default route
    program_regs('0, 1'b1, $urandom, 1'b0);
    run_phase(150);

    // default off again, random root among nodes 0 to 7
    program_regs(ipv4_trie_pkg::IDX_W'($urandom_range(0, 7)), 1'b0, $urandom, 1'b1);
    run_phase(150);

    if (n_errors == 0) begin
      $display("PASS ipv4_stride8_trie_lookup");
    end else begin
      $display("FAIL ipv4_stride8_trie_lookup");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ipv4_trie_pkg.sv
rtl/ipv4_trie_if.sv
rtl/ipv4_trie_store.sv
rtl/ipv4_trie_cell.sv
rtl/ipv4_trie_result.sv
rtl/ipv4_stride8_trie_lookup.sv
rtl/ipv4_trie_chk.sv
tb/testbench.sv
